[src/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg: shared constants, scaling factors and twiddle functions
// Grid size, fixed-point widths, quarter-wave table and state codes.
// ----------------------------------------------------------------------------
package pps_pkg;
  localparam int GRID_POINTS = 64;
  localparam int LG = $clog2(GRID_POINTS);
  localparam int IW = (LG < 1) ? 1 : LG;
  localparam int STEP = 64 / GRID_POINTS;
  localparam int SW = 40;
  localparam logic [31:0] K_INV_4PI2 = 32'd108792793;
  localparam logic [31:0] K_INV_2PI = 32'd683565276;

  typedef logic signed [SW-1:0] spec_t;
  typedef logic [IW-1:0] idx_t;

  function automatic logic signed [15:0] quarter_sin(input logic [4:0] i);
    case (i)
      5'd0: quarter_sin = 16'sd0;
      5'd1: quarter_sin = 16'sd1606;
      5'd2: quarter_sin = 16'sd3196;
      5'd3: quarter_sin = 16'sd4756;
      5'd4: quarter_sin = 16'sd6270;
      5'd5: quarter_sin = 16'sd7723;
      5'd6: quarter_sin = 16'sd9102;
      5'd7: quarter_sin = 16'sd10394;
      5'd8: quarter_sin = 16'sd11585;
      5'd9: quarter_sin = 16'sd12665;
      5'd10: quarter_sin = 16'sd13623;
      5'd11: quarter_sin = 16'sd14449;
      5'd12: quarter_sin = 16'sd15137;
      5'd13: quarter_sin = 16'sd15679;
      5'd14: quarter_sin = 16'sd16069;
      5'd15: quarter_sin = 16'sd16305;
      5'd16: quarter_sin = 16'sd16384;
      default: quarter_sin = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] tw_cos(input logic [5:0] m);
    if (m <= 6'd16) tw_cos = quarter_sin(5'(6'd16 - m));
    else if (m <= 6'd32) tw_cos = -quarter_sin(5'(m - 6'd16));
    else if (m <= 6'd48) tw_cos = -quarter_sin(5'(6'd48 - m));
    else tw_cos = quarter_sin(5'(m - 6'd48));
  endfunction

  function automatic logic signed [15:0] tw_sin(input logic [5:0] m);
    tw_sin = tw_cos(6'(m + 6'd48));
  endfunction

  // table index for product n*k modulo N
  function automatic logic [5:0] tw_index(input idx_t n, input idx_t k);
    logic [2*IW-1:0] p;
    p = n * k;
    tw_index = 6'(p[IW-1:0] * STEP);
  endfunction

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_FWD  = 3'd1;
  localparam logic [2:0] ST_SPEC = 3'd2;
  localparam logic [2:0] ST_INV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
endpackage

[src/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram: one-write one-read synchronous RAM
// Registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/pps_divider.sv]
// ----------------------------------------------------------------------------
// pps_divider: serial unsigned divider
// Restoring division of a 64-bit numerator by a 13-bit divisor, 1 bit/cycle.
// ----------------------------------------------------------------------------
module pps_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q;
  logic [13:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [12:0] d;
  logic [13:0] sh;

  assign sh = {rem[12:0], q[63]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        rem <= '0;
        d <= den;
        cnt <= 7'd0;
      end else if (busy) begin
        if (sh >= {1'b0, d}) begin
          rem <= sh - {1'b0, d};
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= sh;
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[src/periodic_poisson_solver_1d.sv]
// ----------------------------------------------------------------------------
// periodic_poisson_solver_1d: spectral Poisson solver on a periodic 1D grid
// Loads N density samples, solves in frequency domain, emits N results.
// ----------------------------------------------------------------------------
// Usage: density_sample transactions load one per cycle in grid order. After
// the N-th sample in_ready drops and the block works through the batch:
//   forward DFT  : one multiply-accumulate per cycle
//   spectral step: zero for the mean bin, four serial divisions for every
//                  other bin
//   inverse DFT  : one point per pass, the next begins once the result is accepted
// Each result carries potential, potential_gradient, mean_density and
// last_point (set on the final point). A stalled receiver holds the result
// register and the inverse pass waits; nothing is lost. Input is taken again
// once the last result is accepted. Reset clears the sample count and
// control; the spectrum RAMs are not cleared, every entry is written before
// it is read.
// ----------------------------------------------------------------------------
module periodic_poisson_solver_1d
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] density_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] potential,
  output logic signed [31:0] potential_gradient,
  output logic signed [23:0] mean_density,
  output logic               last_point
);
  // spectral step phases
  localparam logic [1:0] SP_ADDR  = 2'd0;
  localparam logic [1:0] SP_LATCH = 2'd1;
  localparam logic [1:0] SP_DIV   = 2'd2;
  localparam int SH = 14 + LG;

  logic [2:0] state;
  logic [1:0] phase;
  idx_t       ia, ib;         // ia: outer index, ib: issued read address
  idx_t       ib_d;           // address of the data on the RAM outputs
  logic       rd_en;          // a read is issued this cycle
  logic       rd_ok;          // read data valid this cycle
  logic       tail;           // sum over the inner index is complete
  logic       go;             // divider start
  logic signed [63:0] acc0, acc1;
  logic [1:0] sub;            // which of the four divisions
  logic [5:0] tm;
  logic signed [15:0] c, s;   // twiddles aligned with the read data

  // RAM A: density / potential spectrum (re,im)
  logic        wa_en;
  idx_t        wa_addr, ra_addr;
  logic [2*SW-1:0] wa_data, ra_data;
  // RAM G: density spectrum, then gradient spectrum
  logic        wg_en;
  logic [2*SW-1:0] wg_data, rg_data;

  pps_ram #(.WIDTH(2*SW), .DEPTH(GRID_POINTS), .AW(IW)) u_ram_a (
    .clk, .we(wa_en), .waddr(wa_addr), .wdata(wa_data), .raddr(ra_addr), .rdata(ra_data));
  pps_ram #(.WIDTH(2*SW), .DEPTH(GRID_POINTS), .AW(IW)) u_ram_g (
    .clk, .we(wg_en), .waddr(wa_addr), .wdata(wg_data), .raddr(ra_addr), .rdata(rg_data));

  spec_t xre, xim, gre, gim;
  assign xre = spec_t'(ra_data[2*SW-1:SW]);
  assign xim = spec_t'(ra_data[SW-1:0]);
  assign gre = spec_t'(rg_data[2*SW-1:SW]);
  assign gim = spec_t'(rg_data[SW-1:0]);

  assign tm = tw_index(ia, ib);

  // divider
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  logic [12:0] dv_den;
  pps_divider u_div (.clk, .rst, .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo));

  // spectral step values
  logic signed [IW:0] w;
  logic [IW-1:0] aw;
  logic [2*IW-1:0] aw2;
  spec_t sre, sim;
  spec_t phi_re, phi_im, g_re;
  logic signed [23:0] mean;
  logic signed [SW-1:0] mag_src;
  logic [31:0] mag;           // spectrum magnitudes stay below 2^30
  logic [31:0] kc;
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] sres;
  logic [63:0] rq;

  assign w = (ia < idx_t'(GRID_POINTS / 2)) ? $signed({1'b0, ia})
           : $signed({1'b0, ia}) - $signed((IW+1)'(GRID_POINTS));
  assign aw = w[IW] ? IW'(-w) : w[IW-1:0];
  assign aw2 = aw * aw;

  always_comb begin
    case (sub)
      2'd0: mag_src = sre;
      2'd1: mag_src = sim;
      2'd2: mag_src = sim;
      default: mag_src = sre;
    endcase
  end
  assign mag = 32'(mag_src[SW-1] ? -mag_src : mag_src);
  assign kc = (sub < 2'd2) ? K_INV_4PI2 : K_INV_2PI;
  assign dv_num = 64'(mag) * 64'(kc);
  assign dv_den = (sub < 2'd2) ? 13'(aw2) : 13'(aw);
  assign dv_start = go;
  assign rq = (dv_quo + 64'h8000_0000) >> 32;
  assign rnd = SW'(rq);
  // signed result: sgn(src)*r, then the outer sign of each formula
  always_comb begin
    logic neg;
    neg = mag_src[SW-1];
    case (sub)
      2'd0, 2'd1: neg = ~neg;
      2'd2: neg = neg ^ w[IW];
      default: neg = ~(neg ^ w[IW]);
    endcase
    sres = neg ? -rnd : rnd;
  end

  // inverse rounding and saturation
  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction
  logic signed [63:0] rp, rg;
  logic signed [31:0] sp, sg;
  assign rp = (acc0 + (64'sd1 <<< (SH - 1))) >>> SH;
  assign rg = (acc1 + (64'sd1 <<< (SH - 1))) >>> SH;
  assign sp = sat(rp);
  assign sg = sat(rg);

  logic signed [63:0] m0, m1, m2, m3, m4;
  assign m0 = 64'(xre) * 64'(c);
  assign m1 = 64'(xre) * 64'(s);
  assign m2 = 64'(xim) * 64'(s);
  assign m3 = 64'(gre) * 64'(c);
  assign m4 = 64'(gim) * 64'(s);

  logic signed [63:0] fre, fim;
  assign fre = (acc0 + 64'sd8192) >>> 14;
  assign fim = (acc1 + 64'sd8192) >>> 14;

  assign in_ready = (state == ST_LOAD);

  always_comb begin
    wa_en = 1'b0;
    wg_en = 1'b0;
    wa_addr = ia;
    wa_data = {SW'(density_sample), {SW{1'b0}}};
    wg_data = '0;
    ra_addr = ib;
    case (state)
      ST_LOAD: begin
        wa_en = in_valid;
        wa_addr = ib;
      end
      ST_FWD: begin
        wg_en = tail;
        wg_data = {SW'(fre), SW'(fim)};
      end
      ST_SPEC: begin
        ra_addr = ia;
        if (phase == SP_LATCH && ia == '0) begin
          // mean bin: potential and gradient are zero
          wa_en = 1'b1;
          wg_en = 1'b1;
          wa_data = '0;
          wg_data = '0;
        end else if (phase == SP_DIV && dv_done && sub == 2'd3) begin
          wa_en = 1'b1;
          wg_en = 1'b1;
          wa_data = {phi_re, phi_im};
          wg_data = {g_re, sres};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      phase <= SP_ADDR;
      ia <= '0;
      ib <= '0;
      rd_en <= 1'b0;
      rd_ok <= 1'b0;
      tail <= 1'b0;
      go <= 1'b0;
      out_valid <= 1'b0;
      sub <= '0;
    end else begin
      rd_ok <= rd_en;
      ib_d <= ib;
      c <= tw_cos(tm);
      s <= tw_sin(tm);
      tail <= rd_ok && (ib_d == idx_t'(GRID_POINTS - 1));
      go <= (state == ST_SPEC) &&
            ((phase == SP_LATCH && ia != '0) ||
             (phase == SP_DIV && dv_done && sub != 2'd3));
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            ib <= ib + idx_t'(1);
            if (ib == idx_t'(GRID_POINTS - 1)) begin
              state <= ST_FWD;
              ia <= '0;
              ib <= '0;
              rd_en <= 1'b1;
              acc0 <= '0;
              acc1 <= '0;
            end
          end
        end
        ST_FWD: begin
          // ia is bin k, the inner index walks the samples
          if (tail) begin
            acc0 <= '0;
            acc1 <= '0;
            if (ia == '0) mean <= 24'((fre + (64'sd1 <<< (LG - 1))) >>> LG);
            if (ia == idx_t'(GRID_POINTS - 1)) begin
              state <= ST_SPEC;
              phase <= SP_ADDR;
              ia <= '0;
            end else begin
              ia <= ia + idx_t'(1);
              ib <= '0;
              rd_en <= 1'b1;
            end
          end else begin
            if (rd_ok) begin
              acc0 <= acc0 + m0;
              acc1 <= acc1 - m1;
            end
            if (rd_en) begin
              if (ib == idx_t'(GRID_POINTS - 1)) rd_en <= 1'b0;
              else ib <= ib + idx_t'(1);
            end
          end
        end
        ST_SPEC: begin
          case (phase)
            SP_ADDR: phase <= SP_LATCH;
            SP_LATCH: begin
              sre <= gre;
              sim <= gim;
              sub <= 2'd0;
              if (ia == '0) begin
                ia <= ia + idx_t'(1);
                phase <= SP_ADDR;
              end else begin
                phase <= SP_DIV;
              end
            end
            SP_DIV: begin
              if (dv_done) begin
                case (sub)
                  2'd0: phi_re <= sres;
                  2'd1: phi_im <= sres;
                  2'd2: g_re <= sres;
                  default: ;
                endcase
                sub <= sub + 2'd1;
                if (sub == 2'd3) begin
                  phase <= SP_ADDR;
                  if (ia == idx_t'(GRID_POINTS - 1)) begin
                    state <= ST_INV;
                    ia <= '0;
                    ib <= '0;
                    rd_en <= 1'b1;
                    acc0 <= '0;
                    acc1 <= '0;
                  end else begin
                    ia <= ia + idx_t'(1);
                  end
                end
              end
            end
            default: phase <= SP_ADDR;
          endcase
        end
        ST_INV: begin
          // ia is grid point n, the inner index walks the bins
          if (tail) begin
            state <= ST_OUT;
            out_valid <= 1'b1;
            potential <= sp;
            potential_gradient <= sg;
            mean_density <= mean;
            last_point <= (ia == idx_t'(GRID_POINTS - 1));
          end else begin
            if (rd_ok) begin
              acc0 <= acc0 + m0 - m2;
              acc1 <= acc1 + m3 - m4;
            end
            if (rd_en) begin
              if (ib == idx_t'(GRID_POINTS - 1)) rd_en <= 1'b0;
              else ib <= ib + idx_t'(1);
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            ib <= '0;
            if (last_point) begin
              state <= ST_LOAD;
              ia <= '0;
            end else begin
              state <= ST_INV;
              ia <= ia + idx_t'(1);
              rd_en <= 1'b1;
              acc0 <= '0;
              acc1 <= '0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !in_ready) else $error("input accepted while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_OUT) else $error("result outside output phase");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(potential))
    else $error("result dropped while stalled");
endmodule
